@@ sv/cte_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and helper functions of the config token extractor
package cte_pkg;

   localparam int MAX_ITEMS = 4;
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int IDX_W     = $clog2(MAX_ITEMS);

   // result kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // delimiter classes
   localparam logic [2:0] CLS_EOL       = 3'd0;
   localparam logic [2:0] CLS_SPACE     = 3'd1;
   localparam logic [2:0] CLS_HASH      = 3'd2;
   localparam logic [2:0] CLS_EQUALS    = 3'd3;
   localparam logic [2:0] CLS_SEMICOLON = 3'd4;
   localparam logic [2:0] CLS_PATTERN   = 3'd5;

   // quote modes
   localparam logic [1:0] QUOTE_NONE   = 2'd0;
   localparam logic [1:0] QUOTE_SINGLE = 2'd1;
   localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

   // register indexes
   localparam logic [2:0] REG_SPACE_IN_TOKEN     = 3'd0;
   localparam logic [2:0] REG_HASH_IN_TOKEN      = 3'd1;
   localparam logic [2:0] REG_EQUAL_ENDS_TOKEN   = 3'd2;
   localparam logic [2:0] REG_SEMICOLON_IN_TOKEN = 3'd3;
   localparam logic [2:0] REG_PATTERN_CHARS_END  = 3'd4;
   localparam logic [2:0] REG_QUOTES_LITERAL     = 3'd5;
   localparam logic [2:0] REG_CARET_CONDENSE     = 3'd6;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // characters
   localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_CARET     = 8'h5e;
   localparam logic [7:0] CHAR_LBRACKET  = 8'h5b;
   localparam logic [7:0] CHAR_HASH      = 8'h23;
   localparam logic [7:0] CHAR_EQUALS    = 8'h3d;
   localparam logic [7:0] CHAR_SEMI      = 8'h3b;
   localparam logic [7:0] CHAR_TILDE     = 8'h7e;
   localparam logic [7:0] CHAR_BANG      = 8'h21;
   localparam logic [7:0] CHAR_BAR       = 8'h7c;
   localparam logic [7:0] CHAR_ESC       = 8'h1b;
   localparam logic [7:0] CHAR_CR        = 8'h0d;
   localparam logic [7:0] CHAR_LF        = 8'h0a;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_FF        = 8'h0c;
   localparam logic [7:0] CTRL_BASE      = 8'h40;
   localparam logic [7:0] CTRL_MASK      = 8'h7f;
   localparam logic [11:0] OCT_BIAS      = 12'd3504;

   typedef enum logic [2:0] {
      PH_LINE  = 3'd0,
      PH_AFTER = 3'd1,
      PH_TOKEN = 3'd2,
      PH_ESC   = 3'd3,
      PH_CTRL  = 3'd4,
      PH_CARET = 3'd5,
      PH_OCT1  = 3'd6,
      PH_OCT2  = 3'd7
   } phase_type;

   typedef struct packed {
      logic caret_condense;
      logic quotes_literal;
      logic pattern_chars_end;
      logic semicolon_in_token;
      logic equal_ends_token;
      logic hash_in_token;
      logic space_in_token;
   } cfg_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_line;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] item_kind;
      logic [2:0] delimiter_class;
      logic [7:0] delimiter_byte;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      phase_type  phase;
      logic [1:0] quote;
      logic [7:0] held_first;
      logic [7:0] held_second;
   } state_type;

   typedef struct packed {
      logic       emit;
      rsp_type    item;
      phase_type  phase;
      logic [1:0] quote;
   } tok_type;

   function automatic logic is_ws(input logic [7:0] b);
      return b inside {8'h20, [8'h09:8'h0d]};
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b inside {["0":"9"]};
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return b inside {["a":"z"], ["A":"Z"]};
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] b);
      return (b inside {["a":"z"]}) ? b - 8'd32 : b;
   endfunction

   function automatic rsp_type byte_item(input logic [7:0] b);
      rsp_type r;
      r = '0;
      r.out_byte = b;
      r.item_kind = KIND_BYTE;
      return r;
   endfunction

   function automatic logic [2:0] delim_class(input logic [7:0] b, input cfg_type cfg);
      logic [2:0] c;
      c = CLS_EOL;
      if (is_ws(b) && !cfg.space_in_token) c = CLS_SPACE;
      else if (b == CHAR_HASH && !cfg.hash_in_token) c = CLS_HASH;
      else if (b == CHAR_EQUALS && cfg.equal_ends_token) c = CLS_EQUALS;
      else if (b == CHAR_SEMI && !cfg.semicolon_in_token) c = CLS_SEMICOLON;
      else if (cfg.pattern_chars_end &&
               (b == CHAR_TILDE || b == CHAR_BANG || b == CHAR_BAR)) c = CLS_PATTERN;
      return c;
   endfunction

   // one plain token byte: delimiter, quote, escape start, caret start or data
   function automatic tok_type tok_eval(input logic [7:0] b, input logic [1:0] quote,
                                        input cfg_type cfg);
      tok_type    t;
      logic [2:0] cls;
      logic [7:0] qc;
      t = '0;
      t.phase = PH_TOKEN;
      t.quote = quote;
      cls = delim_class(b, cfg);
      qc = (quote == QUOTE_SINGLE) ? CHAR_SQUOTE :
           ((quote == QUOTE_DOUBLE) ? CHAR_DQUOTE : 8'h00);
      if (quote == QUOTE_NONE && cls != CLS_EOL) begin
         t.emit = 1'b1;
         t.item.item_kind = KIND_END;
         t.item.delimiter_class = cls;
         t.item.delimiter_byte = b;
         t.phase = PH_AFTER;
      end else if (quote != QUOTE_NONE && b == qc) begin
         t.quote = QUOTE_NONE;
      end else if (quote == QUOTE_NONE && !cfg.quotes_literal &&
                   (b == CHAR_SQUOTE || b == CHAR_DQUOTE)) begin
         t.quote = (b == CHAR_SQUOTE) ? QUOTE_SINGLE : QUOTE_DOUBLE;
      end else if (b == CHAR_BACKSLASH && quote != QUOTE_SINGLE) begin
         t.phase = PH_ESC;
      end else if (b == CHAR_CARET && cfg.caret_condense) begin
         t.phase = PH_CARET;
      end else begin
         t.emit = 1'b1;
         t.item = byte_item(b);
      end
      return t;
   endfunction

endpackage

@@ sv/cte_csr.sv @@
`timescale 1ns / 1ps
// configuration registers behind the apb-style port
module cte_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [cte_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [cte_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [cte_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output cte_pkg::cfg_type               cfg
);

   cte_pkg::cfg_type cfg_ff;
   cte_pkg::cfg_type cfg_in;
   logic [2:0]       reg_idx;
   logic             wr_en;
   logic             rd_bit;

   assign reg_idx    = csr_paddr[cte_pkg::CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            cte_pkg::REG_SPACE_IN_TOKEN:     cfg_in.space_in_token     = csr_pwdata[0];
            cte_pkg::REG_HASH_IN_TOKEN:      cfg_in.hash_in_token      = csr_pwdata[0];
            cte_pkg::REG_EQUAL_ENDS_TOKEN:   cfg_in.equal_ends_token   = csr_pwdata[0];
            cte_pkg::REG_SEMICOLON_IN_TOKEN: cfg_in.semicolon_in_token = csr_pwdata[0];
            cte_pkg::REG_PATTERN_CHARS_END:  cfg_in.pattern_chars_end  = csr_pwdata[0];
            cte_pkg::REG_QUOTES_LITERAL:     cfg_in.quotes_literal     = csr_pwdata[0];
            cte_pkg::REG_CARET_CONDENSE:     cfg_in.caret_condense     = csr_pwdata[0];
            default:                         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         cte_pkg::REG_SPACE_IN_TOKEN:     rd_bit = cfg_ff.space_in_token;
         cte_pkg::REG_HASH_IN_TOKEN:      rd_bit = cfg_ff.hash_in_token;
         cte_pkg::REG_EQUAL_ENDS_TOKEN:   rd_bit = cfg_ff.equal_ends_token;
         cte_pkg::REG_SEMICOLON_IN_TOKEN: rd_bit = cfg_ff.semicolon_in_token;
         cte_pkg::REG_PATTERN_CHARS_END:  rd_bit = cfg_ff.pattern_chars_end;
         cte_pkg::REG_QUOTES_LITERAL:     rd_bit = cfg_ff.quotes_literal;
         cte_pkg::REG_CARET_CONDENSE:     rd_bit = cfg_ff.caret_condense;
         default:                         rd_bit = 1'b0;
      endcase
   end

   assign csr_prdata = {{(cte_pkg::CSR_DATA_W-1){1'b0}}, rd_bit};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ sv/cte_step.sv @@
`timescale 1ns / 1ps
// per-byte tokenizer step: next state and the result items of one byte
module cte_step (
   input  cte_pkg::req_type                          req,
   input  cte_pkg::cfg_type                          cfg,
   input  cte_pkg::state_type                        cur,
   output cte_pkg::state_type                        nxt,
   output cte_pkg::rsp_type [cte_pkg::MAX_ITEMS-1:0] items,
   output logic [cte_pkg::CNT_W-1:0]                 count
);

   cte_pkg::tok_type   tok;
   cte_pkg::state_type mid;
   logic [7:0]         b;
   logic [7:0]         up;
   logic [7:0]         oct_val;
   logic [7:0]         ctrl_val;

   assign b   = req.in_byte;
   assign up  = cte_pkg::to_upper(b);
   assign tok = cte_pkg::tok_eval(b, cur.quote, cfg);

   // three-digit escape, wrapped to 8 bits
   assign oct_val = {cur.held_first[1:0], 6'b0} + {cur.held_second[4:0], 3'b0} + b
                    - cte_pkg::OCT_BIAS[7:0];
   assign ctrl_val = (up - cte_pkg::CTRL_BASE) & cte_pkg::CTRL_MASK;

   // next state
   always_comb begin
      mid = cur;
      case (cur.phase)
         cte_pkg::PH_LINE, cte_pkg::PH_AFTER: begin
            if (!cte_pkg::is_ws(b)) begin
               mid.phase = tok.phase;
               mid.quote = tok.quote;
            end
         end
         cte_pkg::PH_TOKEN: begin
            mid.phase = tok.phase;
            mid.quote = tok.quote;
         end
         cte_pkg::PH_ESC: begin
            if (b == "c" || b == "C") begin
               mid.phase = cte_pkg::PH_CTRL;
            end else if (cte_pkg::is_digit(b)) begin
               mid.held_first = b;
               mid.phase = cte_pkg::PH_OCT1;
            end else begin
               mid.phase = cte_pkg::PH_TOKEN;
            end
         end
         cte_pkg::PH_CTRL, cte_pkg::PH_CARET: begin
            mid.phase = cte_pkg::PH_TOKEN;
         end
         cte_pkg::PH_OCT1: begin
            if (cte_pkg::is_digit(b)) begin
               mid.held_second = b;
               mid.phase = cte_pkg::PH_OCT2;
            end else begin
               mid.phase = tok.phase;
               mid.quote = tok.quote;
            end
         end
         cte_pkg::PH_OCT2: begin
            if (cte_pkg::is_digit(b)) begin
               mid.phase = cte_pkg::PH_TOKEN;
            end else begin
               mid.phase = tok.phase;
               mid.quote = tok.quote;
            end
         end
         default: mid = cur;
      endcase

      nxt = mid;
      if (req.end_of_line) begin
         nxt.phase = cte_pkg::PH_LINE;
         nxt.quote = cte_pkg::QUOTE_NONE;
         nxt.held_first = 8'h00;
         nxt.held_second = 8'h00;
      end
   end

   // result items
   always_comb begin
      cte_pkg::rsp_type          it;
      logic [cte_pkg::CNT_W-1:0] n;
      items = '0;
      n = '0;
      it = '0;
      case (cur.phase)
         cte_pkg::PH_LINE, cte_pkg::PH_AFTER, cte_pkg::PH_TOKEN: begin
            if ((cur.phase == cte_pkg::PH_TOKEN || !cte_pkg::is_ws(b)) && tok.emit) begin
               items[n[cte_pkg::IDX_W-1:0]] = tok.item;
               n = n + 1'b1;
            end
         end
         cte_pkg::PH_ESC: begin
            it = cte_pkg::byte_item(b);
            case (b)
               "r":     it = cte_pkg::byte_item(cte_pkg::CHAR_CR);
               "n":     it = cte_pkg::byte_item(cte_pkg::CHAR_LF);
               "t":     it = cte_pkg::byte_item(cte_pkg::CHAR_TAB);
               "f":     it = cte_pkg::byte_item(cte_pkg::CHAR_FF);
               "e":     it = cte_pkg::byte_item(cte_pkg::CHAR_ESC);
               default: it = cte_pkg::byte_item(b);
            endcase
            if (!(b == "c" || b == "C" || cte_pkg::is_digit(b))) begin
               items[n[cte_pkg::IDX_W-1:0]] = it;
               n = n + 1'b1;
            end
         end
         cte_pkg::PH_CTRL: begin
            items[n[cte_pkg::IDX_W-1:0]] = cte_pkg::byte_item(ctrl_val);
            n = n + 1'b1;
         end
         cte_pkg::PH_CARET: begin
            if (b == cte_pkg::CHAR_CARET) begin
               items[n[cte_pkg::IDX_W-1:0]] = cte_pkg::byte_item(b);
               n = n + 1'b1;
            end else if (b == cte_pkg::CHAR_LBRACKET) begin
               items[n[cte_pkg::IDX_W-1:0]] = cte_pkg::byte_item(cte_pkg::CHAR_ESC);
               n = n + 1'b1;
            end else if (cte_pkg::is_alpha(b)) begin
               items[n[cte_pkg::IDX_W-1:0]] = cte_pkg::byte_item(up - cte_pkg::CTRL_BASE);
               n = n + 1'b1;
            end else begin
               items[n[cte_pkg::IDX_W-1:0]] = cte_pkg::byte_item(cte_pkg::CHAR_CARET);
               n = n + 1'b1;
               items[n[cte_pkg::IDX_W-1:0]] = cte_pkg::byte_item(b);
               n = n + 1'b1;
            end
         end
         cte_pkg::PH_OCT1: begin
            if (!cte_pkg::is_digit(b)) begin
               items[n[cte_pkg::IDX_W-1:0]] = cte_pkg::byte_item(cur.held_first);
               n = n + 1'b1;
               if (tok.emit) begin
                  items[n[cte_pkg::IDX_W-1:0]] = tok.item;
                  n = n + 1'b1;
               end
            end
         end
         cte_pkg::PH_OCT2: begin
            if (cte_pkg::is_digit(b)) begin
               items[n[cte_pkg::IDX_W-1:0]] = cte_pkg::byte_item(oct_val);
               n = n + 1'b1;
            end else begin
               items[n[cte_pkg::IDX_W-1:0]] = cte_pkg::byte_item(cur.held_first);
               n = n + 1'b1;
               items[n[cte_pkg::IDX_W-1:0]] = cte_pkg::byte_item(cur.held_second);
               n = n + 1'b1;
               if (tok.emit) begin
                  items[n[cte_pkg::IDX_W-1:0]] = tok.item;
                  n = n + 1'b1;
               end
            end
         end
         default: n = '0;
      endcase

      // line end: error on a dangling escape, else flush held digits and close
      if (req.end_of_line) begin
         if (mid.phase == cte_pkg::PH_ESC || mid.phase == cte_pkg::PH_CTRL ||
             mid.phase == cte_pkg::PH_CARET) begin
            it = '0;
            it.item_kind = cte_pkg::KIND_ERROR;
            items[n[cte_pkg::IDX_W-1:0]] = it;
            n = n + 1'b1;
         end else begin
            if (mid.phase == cte_pkg::PH_OCT1 || mid.phase == cte_pkg::PH_OCT2) begin
               items[n[cte_pkg::IDX_W-1:0]] = cte_pkg::byte_item(mid.held_first);
               n = n + 1'b1;
            end
            if (mid.phase == cte_pkg::PH_OCT2) begin
               items[n[cte_pkg::IDX_W-1:0]] = cte_pkg::byte_item(mid.held_second);
               n = n + 1'b1;
            end
            if (mid.phase != cte_pkg::PH_AFTER) begin
               it = '0;
               it.item_kind = cte_pkg::KIND_END;
               it.delimiter_class = cte_pkg::CLS_EOL;
               items[n[cte_pkg::IDX_W-1:0]] = it;
               n = n + 1'b1;
            end
         end
      end

      for (int i = 0; i < cte_pkg::MAX_ITEMS; i++) begin
         if (n != '0 && i == int'(n) - 1) items[i].last_of_run = 1'b1;
      end
      count = n;
   end

endmodule

@@ sv/cte_out_buf.sv @@
`timescale 1ns / 1ps
// result register group: holds the items of one byte and hands them out one by one
module cte_out_buf (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      load,
   input  cte_pkg::rsp_type [cte_pkg::MAX_ITEMS-1:0] load_items,
   input  logic [cte_pkg::CNT_W-1:0]                 load_count,
   output logic                                      free,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output cte_pkg::rsp_type                          rsp_data
);

   cte_pkg::rsp_type [cte_pkg::MAX_ITEMS-1:0] items_ff;
   logic [cte_pkg::CNT_W-1:0]                 cnt_ff;
   logic [cte_pkg::CNT_W-1:0]                 cnt_in;
   logic [cte_pkg::IDX_W-1:0]                 idx_ff;
   logic [cte_pkg::IDX_W-1:0]                 idx_in;
   logic                                      out_take;
   logic                                      at_last;

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data  = items_ff[idx_ff];
   assign out_take  = rsp_valid && !rsp_stall;
   assign at_last   = ({1'b0, idx_ff} == cnt_ff - 1'b1);
   assign free      = !rsp_valid || (out_take && at_last);

   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (out_take) begin
         if (at_last) begin
            cnt_in = '0;
            idx_in = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
      if (load) begin
         cnt_in = load_count;
         idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         items_ff <= load_items;
      end
   end

endmodule

@@ sv/config_token_extractor.sv @@
`timescale 1ns / 1ps
// top level of the config token extractor
//
// Line bytes enter on the req_ channel, one item per byte, with end_of_line
// on the last byte of a line. Token bytes, token ends and premature end
// errors leave on the rsp_ channel, one result item per handshake, the last
// item caused by a byte flagged by last_of_run. A byte may cause no item.
// Seven one-bit option registers sit behind the csr_ port at byte addresses
// 0, 4, .. 24; write them only while no item is in flight.
// An accepted byte lands in an input register; once the result register
// group is free, the step logic updates the tokenizer state and loads the
// byte's items into that group, which then shows the first item.
// One byte is taken per cycle while each byte causes at most one item and
// the receiver does not stall; a byte with several items holds the input
// until the single result port takes its last item. A receiver stall
// holds the result group; the input register fills, then req_stall rises.
// Reset (synchronous) clears the options, drops any item in flight and
// returns the tokenizer to the start of a line.
module config_token_extractor (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  cte_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output cte_pkg::rsp_type               rsp_data,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [cte_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [cte_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [cte_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   cte_pkg::cfg_type                          cfg;
   cte_pkg::req_type                          in_data_ff;
   logic                                      in_valid_ff;
   logic                                      in_valid_in;
   cte_pkg::state_type                        state_ff;
   cte_pkg::state_type                        state_in;
   cte_pkg::rsp_type [cte_pkg::MAX_ITEMS-1:0] step_items;
   logic [cte_pkg::CNT_W-1:0]                 step_count;
   logic                                      buf_free;
   logic                                      advance;
   logic                                      in_take;

   cte_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cte_step u_step (
      .req   (in_data_ff),
      .cfg   (cfg),
      .cur   (state_ff),
      .nxt   (state_in),
      .items (step_items),
      .count (step_count)
   );

   cte_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && step_count != '0),
      .load_items (step_items),
      .load_count (step_count),
      .free       (buf_free),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   // the held byte moves on once the result group can take its items
   assign advance   = in_valid_ff && buf_free;
   assign req_stall = in_valid_ff && !buf_free;
   assign in_take   = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_take) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff <= '{phase: cte_pkg::PH_LINE, quote: cte_pkg::QUOTE_NONE,
                       held_first: 8'h00, held_second: 8'h00};
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) in_data_ff <= req_data;
   end

   a_stall_needs_held_byte: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled with an empty input register");

   a_line_end_resets_state: assert property (@(posedge clock) disable iff (reset)
      (advance && in_data_ff.end_of_line) |=>
         (state_ff.phase == cte_pkg::PH_LINE && state_ff.quote == cte_pkg::QUOTE_NONE))
      else $error("tokenizer state not back at line start after a line end");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.item_kind == cte_pkg::KIND_ERROR) |-> rsp_data.last_of_run)
      else $error("error item not the last item of its byte");

   a_no_load_over_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !advance)
      else $error("result group reloaded while an item is still pending");

endmodule
